/* rtl/core/ppcr_pkg.sv */
package ppcr_pkg;

   localparam int NORM_BITS = 30;
   localparam int GAIN_SHIFT = 17;

   localparam logic [1:0] CSR_RADIUS = 2'd0;
   localparam logic [1:0] CSR_GAIN   = 2'd1;
   localparam logic [1:0] CSR_REST   = 2'd2;

   localparam logic [1:0] OUT_RESOLVED   = 2'd0;
   localparam logic [1:0] OUT_SEPARATING = 2'd1;
   localparam logic [1:0] OUT_COINCIDENT = 2'd2;

   localparam logic [31:0] RADIUS_RESET = 32'd65536;
   localparam logic [15:0] GAIN_RESET   = 16'd13107;
   localparam logic [15:0] REST_RESET   = 16'd45220;

   typedef struct packed {
      logic signed [31:0] a_pos_x;
      logic signed [31:0] a_pos_y;
      logic signed [31:0] b_pos_x;
      logic signed [31:0] b_pos_y;
      logic signed [31:0] a_vel_x;
      logic signed [31:0] a_vel_y;
      logic signed [31:0] b_vel_x;
      logic signed [31:0] b_vel_y;
   } pair_type;

   // travels beside the square root
   typedef struct packed {
      pair_type    pair;
      logic [32:0] ux;
      logic [32:0] uy;
      logic        sx;
      logic        sy;
      logic        half;
   } root_carry_type;

   // travels beside the normal division
   typedef struct packed {
      pair_type    pair;
      logic [32:0] dist_val;
      logic        sx;
      logic        sy;
      logic        coin;
      logic        bx;
      logic        by;
   } div_carry_type;

   // travels through the impulse stages
   typedef struct packed {
      pair_type    pair;
      logic        coin;
      logic        sx;
      logic        sy;
      logic [30:0] nx;
      logic [30:0] ny;
   } mid_type;

   function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
      if (v > 39'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -39'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

endpackage

/* rtl/core/particle_pair_collision_resolve_top.sv */
// Collision resolve for one pair of equal circles per beat.
// Request channel: req_valid / req_stall with both positions and both velocities
// in signed fixed point. Response channel: rsp_valid / rsp_stall with corrected
// positions, resolved velocities and an outcome code (resolved, separating,
// coincident). A beat moves when valid is high and stall is low.
// Configuration: csr_we with csr_index / csr_wdata writes radius, correction gain
// and restitution; write only while no pair is in flight.
// Pipeline: 76 register stages from the request to the response register. The
// square root takes one result bit per stage (32 stages) and the two normal
// divisions one quotient bit per stage (31 stages); the rest is a short chain of
// multiply and round stages.
// Throughput: one pair per cycle while no waiting response is held by rsp_stall.
// When rsp_stall holds a waiting response, the whole pipeline freezes and
// req_stall is raised in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and restores the
// register defaults: radius 1.0, gain 0.2, restitution 0.69.
module particle_pair_collision_resolve_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_a_pos_x,
   input  logic signed [31:0] req_a_pos_y,
   input  logic signed [31:0] req_b_pos_x,
   input  logic signed [31:0] req_b_pos_y,
   input  logic signed [31:0] req_a_vel_x,
   input  logic signed [31:0] req_a_vel_y,
   input  logic signed [31:0] req_b_vel_x,
   input  logic signed [31:0] req_b_vel_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_new_a_pos_x,
   output logic signed [31:0] rsp_new_a_pos_y,
   output logic signed [31:0] rsp_new_b_pos_x,
   output logic signed [31:0] rsp_new_b_pos_y,
   output logic signed [31:0] rsp_new_a_vel_x,
   output logic signed [31:0] rsp_new_a_vel_y,
   output logic signed [31:0] rsp_new_b_vel_x,
   output logic signed [31:0] rsp_new_b_vel_y,
   output logic [1:0]         rsp_outcome,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int SQ_N = 32;
   localparam int DV_N = 31;
   // distance below one millionth of a unit counts as coincident
   localparam logic [32:0] COIN_MAX = 33'(((1 << FRAC_BITS) - 1) / 1000000);

   logic adv;

   // ---------------- configuration ----------------
   logic [31:0] radius_ff;
   logic [15:0] gain_ff;
   logic [15:0] rest_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ppcr_pkg::RADIUS_RESET;
         gain_ff   <= ppcr_pkg::GAIN_RESET;
         rest_ff   <= ppcr_pkg::REST_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            ppcr_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            ppcr_pkg::CSR_GAIN:   gain_ff   <= csr_wdata[15:0];
            ppcr_pkg::CSR_REST:   rest_ff   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // ---------------- front: differences and squares ----------------
   logic signed [32:0] dx, dy;
   logic [32:0] ux, uy;
   logic half;
   ppcr_pkg::pair_type req_pair;

   assign req_pair = '{req_a_pos_x, req_a_pos_y, req_b_pos_x, req_b_pos_y,
                       req_a_vel_x, req_a_vel_y, req_b_vel_x, req_b_vel_y};
   assign dx = {req_a_pos_x[31], req_a_pos_x} - {req_b_pos_x[31], req_b_pos_x};
   assign dy = {req_a_pos_y[31], req_a_pos_y} - {req_b_pos_y[31], req_b_pos_y};
   assign ux = dx[32] ? (~dx + 33'd1) : dx;
   assign uy = dy[32] ? (~dy + 33'd1) : dy;
   assign half = ux[32] | ux[31] | uy[32] | uy[31];

   logic f1_v_ff, f2_v_ff;
   ppcr_pkg::root_carry_type f1_c_ff, f2_c_ff;
   logic [31:0] f1_ox_ff, f1_oy_ff;
   logic [63:0] f2_sqx_ff, f2_sqy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else if (adv) begin
         f1_v_ff <= req_valid;
         f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_c_ff.pair <= req_pair;
         f1_c_ff.ux   <= ux;
         f1_c_ff.uy   <= uy;
         f1_c_ff.sx   <= dx[32];
         f1_c_ff.sy   <= dy[32];
         f1_c_ff.half <= half;
         f1_ox_ff     <= half ? ux[32:1] : ux[31:0];
         f1_oy_ff     <= half ? uy[32:1] : uy[31:0];
         f2_c_ff      <= f1_c_ff;
         f2_sqx_ff    <= f1_ox_ff * f1_ox_ff;
         f2_sqy_ff    <= f1_oy_ff * f1_oy_ff;
      end
   end

   // ---------------- square root, one bit per stage ----------------
   logic                     sq_v_ff    [0:SQ_N];
   ppcr_pkg::root_carry_type sq_c_ff    [0:SQ_N];
   logic [63:0]              sq_rad_ff  [0:SQ_N];
   logic [31:0]              sq_root_ff [0:SQ_N];
   logic [33:0]              sq_rem_ff  [0:SQ_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= f2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_c_ff[0]    <= f2_c_ff;
         sq_rad_ff[0]  <= f2_sqx_ff + f2_sqy_ff;
         sq_root_ff[0] <= '0;
         sq_rem_ff[0]  <= '0;
      end
   end

   for (genvar i = 0; i < SQ_N; i++) begin : g_sq
      localparam int B = SQ_N - 1 - i;
      logic [35:0] sh, tr;
      logic ge;

      assign sh = {sq_rem_ff[i], sq_rad_ff[i][2*B+1:2*B]};
      assign tr = {2'b00, sq_root_ff[i], 2'b01};
      assign ge = sh >= tr;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[i+1] <= sq_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[i+1]    <= sq_c_ff[i];
            sq_rad_ff[i+1]  <= sq_rad_ff[i];
            sq_root_ff[i+1] <= {sq_root_ff[i][30:0], ge};
            sq_rem_ff[i+1]  <= ge ? 34'(sh - tr) : sh[33:0];
         end
      end
   end

   // ---------------- unit normal, one quotient bit per stage ----------------
   logic [32:0] dist_in;
   assign dist_in = sq_c_ff[SQ_N].half ? {sq_root_ff[SQ_N], 1'b0}
                                       : {1'b0, sq_root_ff[SQ_N]};

   logic                    dv_v_ff  [0:DV_N];
   ppcr_pkg::div_carry_type dv_c_ff  [0:DV_N];
   logic [32:0]             dv_rx_ff [0:DV_N];
   logic [32:0]             dv_ry_ff [0:DV_N];
   logic [30:0]             dv_qx_ff [0:DV_N];
   logic [30:0]             dv_qy_ff [0:DV_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= sq_v_ff[SQ_N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_c_ff[0].pair     <= sq_c_ff[SQ_N].pair;
         dv_c_ff[0].dist_val <= dist_in;
         dv_c_ff[0].sx       <= sq_c_ff[SQ_N].sx;
         dv_c_ff[0].sy       <= sq_c_ff[SQ_N].sy;
         dv_c_ff[0].coin     <= dist_in <= COIN_MAX;
         dv_c_ff[0].bx       <= sq_c_ff[SQ_N].ux[0];
         dv_c_ff[0].by       <= sq_c_ff[SQ_N].uy[0];
         // top quotient bits are known zero, so start from |d| >> 1
         dv_rx_ff[0]     <= {1'b0, sq_c_ff[SQ_N].ux[32:1]};
         dv_ry_ff[0]     <= {1'b0, sq_c_ff[SQ_N].uy[32:1]};
         dv_qx_ff[0]     <= '0;
         dv_qy_ff[0]     <= '0;
      end
   end

   for (genvar j = 0; j < DV_N; j++) begin : g_dv
      logic nbx, nby;
      logic [33:0] shx, shy, dvs;
      logic gex, gey;

      if (j == 0) begin : g_first
         assign nbx = dv_c_ff[j].bx;
         assign nby = dv_c_ff[j].by;
      end else begin : g_rest
         assign nbx = 1'b0;
         assign nby = 1'b0;
      end

      assign dvs = {1'b0, dv_c_ff[j].dist_val};
      assign shx = {dv_rx_ff[j], nbx};
      assign shy = {dv_ry_ff[j], nby};
      assign gex = shx >= dvs;
      assign gey = shy >= dvs;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j+1] <= dv_v_ff[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_c_ff[j+1]  <= dv_c_ff[j];
            dv_rx_ff[j+1] <= gex ? 33'(shx - dvs) : shx[32:0];
            dv_ry_ff[j+1] <= gey ? 33'(shy - dvs) : shy[32:0];
            dv_qx_ff[j+1] <= {dv_qx_ff[j][29:0], gex};
            dv_qy_ff[j+1] <= {dv_qy_ff[j][29:0], gey};
         end
      end
   end

   // ---------------- impulse stages ----------------
   logic m0_v_ff, m1_v_ff, m2_v_ff, m3_v_ff, m4_v_ff, m5_v_ff, m6_v_ff, m7_v_ff;
   ppcr_pkg::mid_type m0_c_ff, m1_c_ff, m2_c_ff, m3_c_ff, m4_c_ff, m5_c_ff, m6_c_ff,
                      m7_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m0_v_ff <= 1'b0;
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         m3_v_ff <= 1'b0;
         m4_v_ff <= 1'b0;
         m5_v_ff <= 1'b0;
         m6_v_ff <= 1'b0;
         m7_v_ff <= 1'b0;
      end else if (adv) begin
         m0_v_ff <= dv_v_ff[DV_N];
         m1_v_ff <= m0_v_ff;
         m2_v_ff <= m1_v_ff;
         m3_v_ff <= m2_v_ff;
         m4_v_ff <= m3_v_ff;
         m5_v_ff <= m4_v_ff;
         m6_v_ff <= m5_v_ff;
         m7_v_ff <= m6_v_ff;
      end
   end

   // stage 0: overlap and relative velocity as sign and magnitude
   logic signed [34:0] ovl;
   logic signed [32:0] rvx, rvy;
   ppcr_pkg::pair_type dv_pair;

   assign dv_pair = dv_c_ff[DV_N].pair;
   assign ovl = $signed({2'b00, dv_c_ff[DV_N].dist_val}) - $signed({2'b00, radius_ff, 1'b0});
   assign rvx = {dv_pair.a_vel_x[31], dv_pair.a_vel_x}
              - {dv_pair.b_vel_x[31], dv_pair.b_vel_x};
   assign rvy = {dv_pair.a_vel_y[31], dv_pair.a_vel_y}
              - {dv_pair.b_vel_y[31], dv_pair.b_vel_y};

   logic [33:0] m0_ovm_ff;
   logic        m0_ovs_ff, m0_rxs_ff, m0_rys_ff;
   logic [32:0] m0_rxm_ff, m0_rym_ff;

   // stage 1 products
   logic [49:0] m1_ps_ff;
   logic [63:0] m1_ptx_ff, m1_pty_ff;
   logic        m1_ss_ff, m1_tsx_ff, m1_tsy_ff;

   // stage 2 rounded magnitudes
   logic [33:0] m2_sm_ff, m2_txm_ff, m2_tym_ff;
   logic        m2_ss_ff, m2_tsx_ff, m2_tsy_ff;

   // stage 3 normal speed and correction products
   logic signed [35:0] m3_vn_ff;
   logic [64:0]        m3_pcx_ff, m3_pcy_ff;
   logic               m3_csx_ff, m3_csy_ff;
   logic signed [35:0] tx_in, ty_in;

   assign tx_in = m2_tsx_ff ? -$signed({2'b00, m2_txm_ff}) : $signed({2'b00, m2_txm_ff});
   assign ty_in = m2_tsy_ff ? -$signed({2'b00, m2_tym_ff}) : $signed({2'b00, m2_tym_ff});

   // stage 4 signed corrections and impulse product
   logic [34:0]        cxm_in, cym_in, vm_in;
   logic signed [35:0] m4_cx_ff, m4_cy_ff;
   logic [51:0]        m4_pk_ff;
   logic               m4_ks_ff, m4_sep_ff;

   assign cxm_in = 35'((m3_pcx_ff + (65'd1 << (ppcr_pkg::NORM_BITS - 1))) >> ppcr_pkg::NORM_BITS);
   assign cym_in = 35'((m3_pcy_ff + (65'd1 << (ppcr_pkg::NORM_BITS - 1))) >> ppcr_pkg::NORM_BITS);
   assign vm_in  = 35'(m3_vn_ff[35] ? -m3_vn_ff : m3_vn_ff);

   // stage 5 corrected positions and impulse magnitude
   logic signed [31:0] m5_apx_ff, m5_apy_ff, m5_bpx_ff, m5_bpy_ff;
   logic [34:0]        m5_km_ff;
   logic               m5_ks_ff, m5_sep_ff;

   // stage 6 impulse products
   logic signed [31:0] m6_apx_ff, m6_apy_ff, m6_bpx_ff, m6_bpy_ff;
   logic [65:0]        m6_pqx_ff, m6_pqy_ff;
   logic               m6_qsx_ff, m6_qsy_ff, m6_sep_ff;

   // stage 7 signed impulse per axis
   logic signed [31:0] m7_apx_ff, m7_apy_ff, m7_bpx_ff, m7_bpy_ff;
   logic signed [36:0] m7_qx_ff, m7_qy_ff;
   logic               m7_sep_ff;
   logic [35:0]        qxm_in, qym_in;

   assign qxm_in = 36'((m6_pqx_ff + (66'd1 << (ppcr_pkg::NORM_BITS - 1))) >> ppcr_pkg::NORM_BITS);
   assign qym_in = 36'((m6_pqy_ff + (66'd1 << (ppcr_pkg::NORM_BITS - 1))) >> ppcr_pkg::NORM_BITS);

   always_ff @(posedge clock) begin
      if (adv) begin
         m0_c_ff.pair <= dv_pair;
         m0_c_ff.coin <= dv_c_ff[DV_N].coin;
         m0_c_ff.sx   <= dv_c_ff[DV_N].sx;
         m0_c_ff.sy   <= dv_c_ff[DV_N].sy;
         m0_c_ff.nx   <= dv_qx_ff[DV_N];
         m0_c_ff.ny   <= dv_qy_ff[DV_N];
         m0_ovs_ff    <= ovl[34];
         m0_ovm_ff    <= 34'(ovl[34] ? -ovl : ovl);
         m0_rxs_ff    <= rvx[32];
         m0_rxm_ff    <= rvx[32] ? 33'(-rvx) : rvx;
         m0_rys_ff    <= rvy[32];
         m0_rym_ff    <= rvy[32] ? 33'(-rvy) : rvy;

         m1_c_ff   <= m0_c_ff;
         m1_ps_ff  <= m0_ovm_ff * gain_ff;
         m1_ptx_ff <= m0_rxm_ff * m0_c_ff.nx;
         m1_pty_ff <= m0_rym_ff * m0_c_ff.ny;
         m1_ss_ff  <= m0_ovs_ff;
         m1_tsx_ff <= m0_rxs_ff ^ m0_c_ff.sx;
         m1_tsy_ff <= m0_rys_ff ^ m0_c_ff.sy;

         m2_c_ff   <= m1_c_ff;
         m2_sm_ff  <= 34'((m1_ps_ff + (50'd1 << (ppcr_pkg::GAIN_SHIFT - 1)))
                          >> ppcr_pkg::GAIN_SHIFT);
         m2_txm_ff <= 34'((m1_ptx_ff + (64'd1 << (ppcr_pkg::NORM_BITS - 1)))
                          >> ppcr_pkg::NORM_BITS);
         m2_tym_ff <= 34'((m1_pty_ff + (64'd1 << (ppcr_pkg::NORM_BITS - 1)))
                          >> ppcr_pkg::NORM_BITS);
         m2_ss_ff  <= m1_ss_ff;
         m2_tsx_ff <= m1_tsx_ff;
         m2_tsy_ff <= m1_tsy_ff;

         m3_c_ff   <= m2_c_ff;
         m3_vn_ff  <= tx_in + ty_in;
         m3_pcx_ff <= m2_sm_ff * m2_c_ff.nx;
         m3_pcy_ff <= m2_sm_ff * m2_c_ff.ny;
         m3_csx_ff <= m2_ss_ff ^ m2_c_ff.sx;
         m3_csy_ff <= m2_ss_ff ^ m2_c_ff.sy;

         m4_c_ff   <= m3_c_ff;
         m4_cx_ff  <= m3_csx_ff ? -$signed({1'b0, cxm_in}) : $signed({1'b0, cxm_in});
         m4_cy_ff  <= m3_csy_ff ? -$signed({1'b0, cym_in}) : $signed({1'b0, cym_in});
         m4_pk_ff  <= vm_in * {1'b1, rest_ff};
         m4_ks_ff  <= m3_vn_ff[35];
         // zero normal speed counts as approaching
         m4_sep_ff <= !m3_vn_ff[35] && (m3_vn_ff != '0);

         m5_c_ff   <= m4_c_ff;
         m5_apx_ff <= ppcr_pkg::sat32(39'(m4_c_ff.pair.a_pos_x) - 39'(m4_cx_ff));
         m5_apy_ff <= ppcr_pkg::sat32(39'(m4_c_ff.pair.a_pos_y) - 39'(m4_cy_ff));
         m5_bpx_ff <= ppcr_pkg::sat32(39'(m4_c_ff.pair.b_pos_x) + 39'(m4_cx_ff));
         m5_bpy_ff <= ppcr_pkg::sat32(39'(m4_c_ff.pair.b_pos_y) + 39'(m4_cy_ff));
         m5_km_ff  <= 35'((m4_pk_ff + (52'd1 << (ppcr_pkg::GAIN_SHIFT - 1)))
                          >> ppcr_pkg::GAIN_SHIFT);
         m5_ks_ff  <= m4_ks_ff;
         m5_sep_ff <= m4_sep_ff;

         m6_c_ff   <= m5_c_ff;
         m6_apx_ff <= m5_apx_ff;
         m6_apy_ff <= m5_apy_ff;
         m6_bpx_ff <= m5_bpx_ff;
         m6_bpy_ff <= m5_bpy_ff;
         m6_pqx_ff <= m5_km_ff * m5_c_ff.nx;
         m6_pqy_ff <= m5_km_ff * m5_c_ff.ny;
         m6_qsx_ff <= m5_ks_ff ^ m5_c_ff.sx;
         m6_qsy_ff <= m5_ks_ff ^ m5_c_ff.sy;
         m6_sep_ff <= m5_sep_ff;

         m7_c_ff   <= m6_c_ff;
         m7_apx_ff <= m6_apx_ff;
         m7_apy_ff <= m6_apy_ff;
         m7_bpx_ff <= m6_bpx_ff;
         m7_bpy_ff <= m6_bpy_ff;
         m7_qx_ff  <= m6_qsx_ff ? -$signed({1'b0, qxm_in}) : $signed({1'b0, qxm_in});
         m7_qy_ff  <= m6_qsy_ff ? -$signed({1'b0, qym_in}) : $signed({1'b0, qym_in});
         m7_sep_ff <= m6_sep_ff;
      end
   end

   // ---------------- output register ----------------
   ppcr_pkg::pair_type res_in, res_ff;
   logic [1:0] outcome_in, outcome_ff;
   logic rsp_valid_ff;
   ppcr_pkg::pair_type m7_pair;

   assign m7_pair = m7_c_ff.pair;

   always_comb begin
      res_in = m7_pair;
      outcome_in = ppcr_pkg::OUT_COINCIDENT;
      if (!m7_c_ff.coin) begin
         res_in.a_pos_x = m7_apx_ff;
         res_in.a_pos_y = m7_apy_ff;
         res_in.b_pos_x = m7_bpx_ff;
         res_in.b_pos_y = m7_bpy_ff;
         outcome_in = ppcr_pkg::OUT_SEPARATING;
         if (!m7_sep_ff) begin
            res_in.a_vel_x = ppcr_pkg::sat32(39'(m7_pair.a_vel_x) - 39'(m7_qx_ff));
            res_in.a_vel_y = ppcr_pkg::sat32(39'(m7_pair.a_vel_y) - 39'(m7_qy_ff));
            res_in.b_vel_x = ppcr_pkg::sat32(39'(m7_pair.b_vel_x) + 39'(m7_qx_ff));
            res_in.b_vel_y = ppcr_pkg::sat32(39'(m7_pair.b_vel_y) + 39'(m7_qy_ff));
            outcome_in = ppcr_pkg::OUT_RESOLVED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= m7_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff     <= res_in;
         outcome_ff <= outcome_in;
      end
   end

   // whole pipeline moves unless a finished beat is held at the output
   assign adv = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_a_pos_x = res_ff.a_pos_x;
   assign rsp_new_a_pos_y = res_ff.a_pos_y;
   assign rsp_new_b_pos_x = res_ff.b_pos_x;
   assign rsp_new_b_pos_y = res_ff.b_pos_y;
   assign rsp_new_a_vel_x = res_ff.a_vel_x;
   assign rsp_new_a_vel_y = res_ff.a_vel_y;
   assign rsp_new_b_vel_x = res_ff.b_vel_x;
   assign rsp_new_b_vel_y = res_ff.b_vel_y;
   assign rsp_outcome     = outcome_ff;

   // ---------------- assertions ----------------
   a_outcome_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outcome == ppcr_pkg::OUT_RESOLVED ||
                     rsp_outcome == ppcr_pkg::OUT_SEPARATING ||
                     rsp_outcome == ppcr_pkg::OUT_COINCIDENT))
      else $error("undefined outcome code on response");

   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      (dv_v_ff[DV_N] && !dv_c_ff[DV_N].coin) |->
         (dv_qx_ff[DV_N] <= (31'd1 << ppcr_pkg::NORM_BITS) &&
          dv_qy_ff[DV_N] <= (31'd1 << ppcr_pkg::NORM_BITS)))
      else $error("normal component above one");

   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(dv_v_ff[DV_N]) && $stable(dv_qx_ff[DV_N]) &&
                $stable(m7_v_ff)))
      else $error("pipeline moved during a stall");

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> f1_v_ff)
      else $error("accepted beat did not enter the pipeline");

endmodule

/* test/particle_pair_collision_resolve_top_tb.sv */
module particle_pair_collision_resolve_top_tb;

   typedef struct {
      ppcr_pkg::pair_type st;
      logic [1:0]         outcome;
   } resolved_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   ppcr_pkg::pair_type req_pair = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   ppcr_pkg::pair_type rsp_pair;
   logic [1:0]         rsp_outcome;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = ppcr_pkg::CSR_RADIUS;
   logic [31:0]        csr_wdata = '0;

   // local copy of the registers
   logic [31:0] radius_r = ppcr_pkg::RADIUS_RESET;
   logic [15:0] gain_r   = ppcr_pkg::GAIN_RESET;
   logic [15:0] rest_r   = ppcr_pkg::REST_RESET;

   resolved_type expected_q[$];
   int        mismatches = 0;
   int        beats_in = 0;
   int        beats_out = 0;
   int        outcome_seen[3] = '{0, 0, 0};
   int        cycles = 0;
   bit        quiet = 1'b0;
   bit        hold_off = 1'b0;
   int        rsp_wait = 0;

   particle_pair_collision_resolve_top u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_a_pos_x(req_pair.a_pos_x), .req_a_pos_y(req_pair.a_pos_y),
      .req_b_pos_x(req_pair.b_pos_x), .req_b_pos_y(req_pair.b_pos_y),
      .req_a_vel_x(req_pair.a_vel_x), .req_a_vel_y(req_pair.a_vel_y),
      .req_b_vel_x(req_pair.b_vel_x), .req_b_vel_y(req_pair.b_vel_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_new_a_pos_x(rsp_pair.a_pos_x), .rsp_new_a_pos_y(rsp_pair.a_pos_y),
      .rsp_new_b_pos_x(rsp_pair.b_pos_x), .rsp_new_b_pos_y(rsp_pair.b_pos_y),
      .rsp_new_a_vel_x(rsp_pair.a_vel_x), .rsp_new_a_vel_y(rsp_pair.a_vel_y),
      .rsp_new_b_vel_x(rsp_pair.b_vel_x), .rsp_new_b_vel_y(rsp_pair.b_vel_y),
      .rsp_outcome(rsp_outcome),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 200000) begin
         $display("timeout with %0d results outstanding", expected_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------- predictor ----------------
   function automatic longint unsigned umag(longint x);
      return x < 0 ? longint'(-x) : x;
   endfunction

   function automatic longint round_mul(longint a, longint b, int sh);
      bit neg;
      longint unsigned p;
      neg = (a < 0) != (b < 0);
      p = umag(a) * umag(b);
      p = (p + (64'd1 << (sh - 1))) >> sh;
      return neg ? -longint'(p) : longint'(p);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint unit_axis(longint d, longint unsigned cdist);
      longint unsigned m;
      m = (umag(d) << ppcr_pkg::NORM_BITS) / cdist;
      if (m > (64'd1 << ppcr_pkg::NORM_BITS)) m = 64'd1 << ppcr_pkg::NORM_BITS;
      return d < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic logic signed [31:0] clip32(longint x);
      if (x > 64'sd2147483647) return 32'sh7fffffff;
      if (x < -64'sd2147483648) return 32'sh80000000;
      return x[31:0];
   endfunction

   function automatic resolved_type resolve_pair(ppcr_pkg::pair_type p);
      resolved_type res;
      longint v[8], r[8];
      longint dx, dy, nx, ny, overlap, s, cx, cy, vn, k, qx, qy;
      longint unsigned ux, uy, cdist;
      v = '{p.a_pos_x, p.a_pos_y, p.b_pos_x, p.b_pos_y,
            p.a_vel_x, p.a_vel_y, p.b_vel_x, p.b_vel_y};
      r = v;
      dx = v[0] - v[2];
      dy = v[1] - v[3];
      ux = umag(dx);
      uy = umag(dy);
      // wide offsets: halve before the root, double after
      if (ux >= 64'd1 << 31 || uy >= 64'd1 << 31)
         cdist = int_sqrt((ux >> 1) * (ux >> 1) + (uy >> 1) * (uy >> 1)) << 1;
      else
         cdist = int_sqrt(ux * ux + uy * uy);
      if (cdist == 0 || cdist * 1000000 < (64'd1 << 16)) begin
         res.outcome = ppcr_pkg::OUT_COINCIDENT;
      end else begin
         nx = unit_axis(dx, cdist);
         ny = unit_axis(dy, cdist);
         overlap = longint'(cdist) - 2 * longint'(radius_r);
         s = round_mul(overlap, longint'(gain_r), ppcr_pkg::GAIN_SHIFT);
         cx = round_mul(s, nx, ppcr_pkg::NORM_BITS);
         cy = round_mul(s, ny, ppcr_pkg::NORM_BITS);
         r[0] = v[0] - cx;
         r[1] = v[1] - cy;
         r[2] = v[2] + cx;
         r[3] = v[3] + cy;
         vn = round_mul(v[4] - v[6], nx, ppcr_pkg::NORM_BITS)
            + round_mul(v[5] - v[7], ny, ppcr_pkg::NORM_BITS);
         if (vn > 0) begin
            res.outcome = ppcr_pkg::OUT_SEPARATING;
         end else begin
            k = round_mul(vn, 65536 + longint'(rest_r), ppcr_pkg::GAIN_SHIFT);
            qx = round_mul(k, nx, ppcr_pkg::NORM_BITS);
            qy = round_mul(k, ny, ppcr_pkg::NORM_BITS);
            r[4] = v[4] - qx;
            r[5] = v[5] - qy;
            r[6] = v[6] + qx;
            r[7] = v[7] + qy;
            res.outcome = ppcr_pkg::OUT_RESOLVED;
         end
      end
      res.st = '{clip32(r[0]), clip32(r[1]), clip32(r[2]), clip32(r[3]),
                 clip32(r[4]), clip32(r[5]), clip32(r[6]), clip32(r[7])};
      return res;
   endfunction

   // ---------------- result side ----------------
   always @(negedge clock) begin
      if (hold_off || rsp_wait > 0) begin
         rsp_stall <= 1'b1;
         if (!hold_off) rsp_wait <= rsp_wait - 1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      resolved_type e;
      logic [31:0] ev[8], gv[8];
      string fname[8];
      if (!reset && rsp_valid && !rsp_stall) begin
         beats_out++;
         rsp_wait <= quiet ? 0 : $urandom_range(0, 9);
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at cycle %0d", cycles);
         end else begin
            e = expected_q.pop_front();
            fname = '{"new_a_pos_x", "new_a_pos_y", "new_b_pos_x", "new_b_pos_y",
                      "new_a_vel_x", "new_a_vel_y", "new_b_vel_x", "new_b_vel_y"};
            ev = '{e.st.a_pos_x, e.st.a_pos_y, e.st.b_pos_x, e.st.b_pos_y,
                   e.st.a_vel_x, e.st.a_vel_y, e.st.b_vel_x, e.st.b_vel_y};
            gv = '{rsp_pair.a_pos_x, rsp_pair.a_pos_y, rsp_pair.b_pos_x, rsp_pair.b_pos_y,
                   rsp_pair.a_vel_x, rsp_pair.a_vel_y, rsp_pair.b_vel_x, rsp_pair.b_vel_y};
            for (int i = 0; i < 8; i++) begin
               if (gv[i] !== ev[i]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("beat %0d %s: expected %h got %h", beats_out, fname[i], ev[i], gv[i]);
               end
            end
            if (rsp_outcome !== e.outcome) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("beat %0d outcome: expected %0d got %0d", beats_out, e.outcome,
                           rsp_outcome);
            end
            if (e.outcome <= ppcr_pkg::OUT_COINCIDENT) outcome_seen[e.outcome]++;
         end
      end
   end

   // ---------------- request side ----------------
   task automatic send_pair(ppcr_pkg::pair_type p);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pair <= p;
      do @(posedge clock); while (req_stall);
      expected_q.push_back(resolve_pair(p));
      beats_in++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] data);
      drain();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ppcr_pkg::CSR_RADIUS: radius_r = data;
         ppcr_pkg::CSR_GAIN:   gain_r = data[15:0];
         ppcr_pkg::CSR_REST:   rest_r = data[15:0];
         default: ;
      endcase
   endtask

   function automatic ppcr_pkg::pair_type make_pair(int kind);
      ppcr_pkg::pair_type p;
      int span;
      p = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      if (kind == 0) begin
         // pair near contact: small offset and moderate speeds
         span = $urandom_range(14, 19);
         p.b_pos_x = $signed($urandom) >>> 8;
         p.b_pos_y = $signed($urandom) >>> 8;
         p.a_pos_x = p.b_pos_x + ($signed($urandom) >>> (32 - span));
         p.a_pos_y = p.b_pos_y + ($signed($urandom) >>> (32 - span));
         p.a_vel_x = $signed($urandom) >>> $urandom_range(8, 14);
         p.a_vel_y = $signed($urandom) >>> $urandom_range(8, 14);
         p.b_vel_x = $signed($urandom) >>> $urandom_range(8, 14);
         p.b_vel_y = $signed($urandom) >>> $urandom_range(8, 14);
      end else if (kind == 1) begin
         p.a_pos_x = p.b_pos_x;
         p.a_pos_y = p.b_pos_y;
      end
      return p;
   endfunction

   // ---------------- tests ----------------
   task automatic test_directed();
      localparam logic signed [31:0] MAXV = 32'sh7fffffff;
      localparam logic signed [31:0] MINV = 32'sh80000000;
      localparam logic signed [31:0] ONE = 32'sh00010000;
      send_pair('{0, 0, 0, 0, 0, 0, 0, 0});
      send_pair('{ONE, 0, 0, 0, -ONE, 0, ONE, 0});
      send_pair('{ONE, 0, 0, 0, ONE, 0, -ONE, 0});
      send_pair('{ONE, ONE, 0, 0, ONE, ONE, ONE, ONE});
      send_pair('{ONE / 2, 0, 0, 0, 0, 0, 0, 0});
      send_pair('{1, 0, 0, 0, 5, 0, 0, 0});
      send_pair('{MAXV, MAXV, MINV, MINV, MINV, MINV, MAXV, MAXV});
      send_pair('{MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, MINV});
      send_pair('{MAXV, 0, MINV, 0, 0, 0, 0, 0});
      send_pair('{MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MINV, MAXV});
      send_pair('{MINV, 0, 0, MINV, MAXV, MINV, MINV, MAXV});
      send_pair('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, MAXV, MAXV, MAXV, MAXV});
      send_pair('{MAXV, -ONE, MAXV - ONE, 0, MINV, MAXV, MAXV, MINV});
      send_pair('{0, 3 * ONE, 0, 0, 0, -MAXV, 0, MAXV});
   endtask

   task automatic test_registers();
      logic [31:0] rad[4] = '{32'd0, 32'hffffffff, 32'd65536, 32'd98304};
      logic [15:0] gn[4] = '{16'd0, 16'hffff, 16'd13107, 16'd40000};
      logic [15:0] rs[4] = '{16'hffff, 16'd0, 16'd45220, 16'd20000};
      for (int c = 0; c < 4; c++) begin
         write_csr(ppcr_pkg::CSR_RADIUS, rad[c]);
         write_csr(ppcr_pkg::CSR_GAIN, {16'd0, gn[c]});
         write_csr(ppcr_pkg::CSR_REST, {16'd0, rs[c]});
         for (int i = 0; i < 30; i++) send_pair(make_pair($urandom_range(0, 3) == 0 ? 2 : 0));
         send_pair(make_pair(1));
         send_pair('{32'sh7fff0000, 0, 32'sh80010000, 0, 32'sh80000000, 0, 32'sh7fffffff, 0});
      end
   endtask

   task automatic test_random();
      int r;
      for (int i = 0; i < 190; i++) begin
         if (i % 50 == 0) quiet = ($urandom_range(0, 2) == 0);
         r = $urandom_range(0, 19);
         send_pair(make_pair(r < 14 ? 0 : (r < 15 ? 1 : 2)));
      end
      quiet = 1'b0;
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (200) @(posedge clock);
            hold_off = 1'b0;
         end
         begin
            quiet = 1'b1;
            for (int i = 0; i < 120; i++) send_pair(make_pair(0));
            quiet = 1'b0;
         end
      join
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random();
      test_backpressure();
      test_registers();
      drain();
      repeat (100) @(posedge clock);
      $display("%0d pairs sent, %0d results checked, %0d mismatches", beats_in, beats_out,
               mismatches);
      $display("outcomes: resolved %0d, separating %0d, coincident %0d; four register settings",
               outcome_seen[0], outcome_seen[1], outcome_seen[2]);
      if (mismatches == 0 && expected_q.size() == 0 && beats_in == beats_out) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
